// ----- design/ptps_pkg.sv -----
// Shared types and constants for the p-state table parser and selector.
package ptps_pkg;

	localparam logic [7:0] PKG_OPCODE   = 8'h12;
	localparam logic [7:0] ENTRY_LENGTH = 8'd32;
	localparam logic [7:0] ENTRY_ELEMS  = 8'd6;
	localparam logic [7:0] DWORD_PREFIX = 8'h0c;
	localparam logic [2:0] WORDS_PER_ENTRY = 3'd6;
	localparam logic [2:0] FREQ_WORD    = 3'd0;
	localparam logic [2:0] CTRL_WORD    = 3'd4;
	localparam logic [2:0] NAME_BYTES_LEFT = 3'd3;
	localparam logic [2:0] MAX_PS_RESET = 3'd7;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_PKG  = 3'd1,
		ST_BAD_ELEN = 3'd2,
		ST_BAD_ECNT = 3'd3,
		ST_BAD_PFX  = 3'd4,
		ST_TOO_MANY = 3'd5,
		ST_LIMIT    = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_START = 3'd1,
		OP_BYTE  = 3'd2,
		OP_SEL   = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data_byte;
		logic [15:0] req_freq;
		logic [3:0]  cpu;
	} item_t;

endpackage

// ----- design/pstate_table_parse_select_core.sv -----
// Top level of the p-state table parser and selector.
// Input channel (in_valid/in_stall): one item per transfer. mode 0 feeds one byte of
// a _PSS package (start_req marks name byte 0), mode 1 selects an entry for
// req_freq and records its hw p-state for cpu, mode 2 reads cpu's current state.
// Output channel (out_valid/out_stall): exactly one result per item, in order.
// Config: cfg_we/cfg_wdata write the hw p-state limit (reset 7). The user writes it
// only while the block is idle; the block itself does not enforce this.
// A table byte passes the queue, then the output register; bytes flow at one per cycle
// while the output is not stalled. A select walks the stored frequencies at one read
// per cycle, then reads the control table, then the frequency, then outputs (an empty
// table goes straight to output); a query reads cpu table and frequency, then outputs.
// A two-entry queue decouples the input from the back end, and an output register
// holds the result; when out_stall is high the result holds, the back end waits,
// the queue fills and in_stall rises.
// Reset clears parser state, the per-cpu p-states (all zero), min/max frequency
// and both channels; the frequency and control tables hold no data until loaded.
module pstate_table_parse_select_core import ptps_pkg::*; #(
	parameter int MAX_STATES = 8,
	parameter int CPU_COUNT  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic        start_req,
	input  logic [7:0]  data_byte,
	input  logic [15:0] req_freq,
	input  logic [3:0]  cpu,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        load_done,
	output logic [2:0]  hw_pstate,
	output logic [15:0] freq_out,
	output logic [15:0] lowest_freq,
	output logic [15:0] highest_freq,
	output logic [3:0]  state_count
);

	logic  head_valid;
	item_t head;
	logic  pop;

	ptps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.start_req   (start_req),
		.data_byte   (data_byte),
		.req_freq    (req_freq),
		.cpu         (cpu),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop)
	);

	ptps_back #(
		.MAX_STATES (MAX_STATES),
		.CPU_COUNT  (CPU_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.load_done    (load_done),
		.hw_pstate    (hw_pstate),
		.freq_out     (freq_out),
		.lowest_freq  (lowest_freq),
		.highest_freq (highest_freq),
		.state_count  (state_count)
	);

endmodule

// ----- design/ptps_front.sv -----
// Front end: classifies incoming items and buffers them in a two-entry queue.
module ptps_front import ptps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic        start_req,
	input  logic [7:0]  data_byte,
	input  logic [15:0] req_freq,
	input  logic [3:0]  cpu,
	output logic        head_valid,
	output item_t       head,
	input  logic        pop
);

	item_t      q_mem [2];
	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	logic       push;
	item_t      item;

	always_comb begin
		item.data_byte   = data_byte;
		item.req_freq    = req_freq;
		item.cpu         = cpu;
		case (mode)
			2'd0:    item.op = start_req ? OP_START : OP_BYTE;
			2'd1:    item.op = OP_SEL;
			2'd2:    item.op = OP_QUERY;
			default: item.op = OP_NOP;
		endcase
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/ptps_back.sv -----
// Back end: table parser, entry selection sequencer, tables and output register.
module ptps_back import ptps_pkg::*; #(
	parameter int MAX_STATES = 8,
	parameter int CPU_COUNT  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        head_valid,
	input  item_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        load_done,
	output logic [2:0]  hw_pstate,
	output logic [15:0] freq_out,
	output logic [15:0] lowest_freq,
	output logic [15:0] highest_freq,
	output logic [3:0]  state_count
);

	localparam int IDX_W = $clog2(MAX_STATES);
	localparam int CNT_W = $clog2(MAX_STATES + 1);
	localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

	typedef enum logic [10:0] {
		PH_IDLE  = 11'b00000000001,
		PH_NAME  = 11'b00000000010,
		PH_PKGOP = 11'b00000000100,
		PH_LEN0  = 11'b00000001000,
		PH_LENX  = 11'b00000010000,
		PH_COUNT = 11'b00000100000,
		PH_EOP   = 11'b00001000000,
		PH_ELEN  = 11'b00010000000,
		PH_ECNT  = 11'b00100000000,
		PH_DPFX  = 11'b01000000000,
		PH_DVAL  = 11'b10000000000
	} phase_t;

	typedef enum logic [4:0] {
		SQ_IDLE = 5'b00001,
		SQ_WALK = 5'b00010,
		SQ_CTL  = 5'b00100,
		SQ_HW   = 5'b01000,
		SQ_FO   = 5'b10000
	} seq_t;

	// parser state
	phase_t      phase_q, phase_d;
	logic [2:0]  byte_pos_q, byte_pos_d;
	logic [7:0]  ent_exp_q, ent_exp_d;
	logic [7:0]  ent_idx_q, ent_idx_d;
	logic [2:0]  word_idx_q, word_idx_d;
	logic [15:0] acc_q, acc_d;
	logic        acc_hi_q, acc_hi_d;
	logic [15:0] min_q, min_d;
	logic [15:0] max_q, max_d;
	logic [2:0]  max_ps_q;
	status_t     p_status;
	logic        p_done;
	logic        fwe;
	logic        cwe;
	logic [15:0] wfreq;
	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] n_d;

	// sequencer state
	seq_t        state_q, state_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic [IDX_W-1:0] pick_q, pick_d;
	logic [15:0] pf_q, pf_d;
	logic [15:0] tgt_q, tgt_d;
	logic [3:0]  cpu_q, cpu_d;
	logic        cpu_ok_q, cpu_ok_d;
	logic        head_cpu_ok;
	logic [2:0]  hw_q, hw_d;
	status_t     st_q, st_d;
	logic        exec_byte;
	logic        out_free;
	logic        load;
	logic [2:0]  hw_c;

	// memories
	logic [15:0] f_mem [MAX_STATES];
	logic [2:0]  c_mem [MAX_STATES];
	logic [2:0]  cur_mem [CPU_COUNT];
	logic [CPU_COUNT-1:0] cur_vld_q;
	logic        f_re, c_re, cur_re, cur_we;
	logic [IDX_W-1:0] f_ra, c_ra;
	logic [CPU_W-1:0] cur_ra, cur_wa;
	logic [2:0]  cur_wd;
	logic [15:0] f_rd_q;
	logic [2:0]  c_rd_q;
	logic [2:0]  cur_rd_q;
	logic        cur_ok_q;

	// output register
	logic        o_valid_q;
	status_t     o_status_q, nx_status;
	logic        o_done_q, nx_done;
	logic [2:0]  o_hw_q, nx_hw;
	logic [15:0] o_fo_q, nx_fo;
	logic [15:0] o_lo_q, nx_lo;
	logic [15:0] o_hi_q, nx_hi;
	logic [3:0]  o_cnt_q, nx_cnt;

	assign n   = (ent_idx_q < 8'(MAX_STATES)) ? ent_idx_q[CNT_W-1:0] : CNT_W'(MAX_STATES);
	assign n_d = (ent_idx_d < 8'(MAX_STATES)) ? ent_idx_d[CNT_W-1:0] : CNT_W'(MAX_STATES);
	assign head_cpu_ok = (7'(head.cpu) < 7'(CPU_COUNT));
	assign out_free    = !o_valid_q || !out_stall;

	// byte parser
	always_comb begin
		phase_d    = phase_q;
		byte_pos_d = byte_pos_q;
		ent_exp_d  = ent_exp_q;
		ent_idx_d  = ent_idx_q;
		word_idx_d = word_idx_q;
		acc_d      = acc_q;
		acc_hi_d   = acc_hi_q;
		min_d      = min_q;
		max_d      = max_q;
		p_status   = ST_OK;
		p_done     = 1'b0;
		fwe        = 1'b0;
		cwe        = 1'b0;
		wfreq      = (acc_hi_q || (head.data_byte != 8'd0)) ? 16'hffff : acc_q;
		if (head.op == OP_START) begin
			phase_d    = PH_NAME;
			byte_pos_d = NAME_BYTES_LEFT;
			ent_exp_d  = 8'd0;
			ent_idx_d  = 8'd0;
			word_idx_d = 3'd0;
			acc_d      = 16'd0;
			acc_hi_d   = 1'b0;
			min_d      = 16'hffff;
			max_d      = 16'd0;
		end else if (head.op == OP_BYTE) begin
			case (phase_q)
				PH_NAME: begin
					byte_pos_d = byte_pos_q - 3'd1;
					if (byte_pos_d == 3'd0) begin
						phase_d = PH_PKGOP;
					end
				end
				PH_PKGOP: begin
					if (head.data_byte != PKG_OPCODE) p_status = ST_BAD_PKG;
					phase_d = PH_LEN0;
				end
				PH_LEN0: begin
					if (head.data_byte[7:6] == 2'd0) begin
						phase_d = PH_COUNT;
					end else begin
						byte_pos_d = {1'b0, head.data_byte[7:6]};
						phase_d    = PH_LENX;
					end
				end
				PH_LENX: begin
					byte_pos_d = byte_pos_q - 3'd1;
					if (byte_pos_d == 3'd0) begin
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					ent_exp_d = head.data_byte;
					ent_idx_d = 8'd0;
					if (head.data_byte > 8'(MAX_STATES)) p_status = ST_TOO_MANY;
					if (head.data_byte == 8'd0) begin
						phase_d = PH_IDLE;
						p_done  = 1'b1;
					end else begin
						phase_d = PH_EOP;
					end
				end
				PH_EOP: begin
					if (head.data_byte != PKG_OPCODE) p_status = ST_BAD_PKG;
					phase_d = PH_ELEN;
				end
				PH_ELEN: begin
					if (head.data_byte != ENTRY_LENGTH) p_status = ST_BAD_ELEN;
					phase_d = PH_ECNT;
				end
				PH_ECNT: begin
					if (head.data_byte != ENTRY_ELEMS) p_status = ST_BAD_ECNT;
					word_idx_d = 3'd0;
					phase_d    = PH_DPFX;
				end
				PH_DPFX: begin
					if (head.data_byte != DWORD_PREFIX) p_status = ST_BAD_PFX;
					acc_d      = 16'd0;
					acc_hi_d   = 1'b0;
					byte_pos_d = 3'd0;
					phase_d    = PH_DVAL;
				end
				PH_DVAL: begin
					case (byte_pos_q[1:0])
						2'd0:    acc_d[7:0]  = head.data_byte;
						2'd1:    acc_d[15:8] = head.data_byte;
						default: acc_hi_d    = acc_hi_q || (head.data_byte != 8'd0);
					endcase
					byte_pos_d = byte_pos_q + 3'd1;
					if (byte_pos_q == 3'd3) begin
						if (ent_idx_q < 8'(MAX_STATES)) begin
							if (word_idx_q == FREQ_WORD) begin
								fwe = 1'b1;
								if (wfreq < min_q) min_d = wfreq;
								if (wfreq > max_q) max_d = wfreq;
							end else if (word_idx_q == CTRL_WORD) begin
								cwe = 1'b1;
							end
						end
						word_idx_d = word_idx_q + 3'd1;
						if (word_idx_d >= WORDS_PER_ENTRY) begin
							ent_idx_d = ent_idx_q + 8'd1;
							if (ent_idx_d >= ent_exp_q) begin
								phase_d = PH_IDLE;
								p_done  = 1'b1;
							end else begin
								phase_d = PH_EOP;
							end
						end else begin
							phase_d = PH_DPFX;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		exec_byte = 1'b0;
		f_re      = 1'b0;
		f_ra      = '0;
		c_re      = 1'b0;
		c_ra      = '0;
		cur_re    = 1'b0;
		cur_ra    = CPU_W'(head.cpu);
		cur_we    = 1'b0;
		cur_wa    = CPU_W'(cpu_q);
		cur_wd    = 3'd0;
		k_d       = k_q;
		pick_d    = pick_q;
		pf_d      = pf_q;
		tgt_d     = tgt_q;
		cpu_d     = cpu_q;
		cpu_ok_d  = cpu_ok_q;
		hw_d      = hw_q;
		st_d      = st_q;
		hw_c      = 3'd0;
		nx_status = st_q;
		nx_done   = 1'b0;
		nx_hw     = hw_q;
		nx_fo     = (5'(hw_q) < 5'(n)) ? f_rd_q : 16'd0;
		nx_lo     = min_q;
		nx_hi     = max_q;
		nx_cnt    = 4'(n);
		case (state_q)
			SQ_IDLE: begin
				if (head_valid) begin
					case (head.op)
						OP_SEL: begin
							pop      = 1'b1;
							tgt_d    = head.req_freq;
							cpu_d    = head.cpu;
							cpu_ok_d = head_cpu_ok;
							if (n == CNT_W'(0)) begin
								hw_d    = 3'd0;
								st_d    = ST_OK;
								cur_we  = head_cpu_ok;
								cur_wa  = CPU_W'(head.cpu);
								state_d = SQ_FO;
							end else begin
								f_re    = 1'b1;
								k_d     = '0;
								state_d = SQ_WALK;
							end
						end
						OP_QUERY: begin
							pop     = 1'b1;
							cur_re  = 1'b1;
							state_d = SQ_HW;
						end
						default: begin
							if (out_free) begin
								pop       = 1'b1;
								load      = 1'b1;
								exec_byte = 1'b1;
								nx_status = p_status;
								nx_done   = p_done;
								nx_hw     = 3'd0;
								nx_fo     = 16'd0;
								nx_lo     = min_d;
								nx_hi     = max_d;
								nx_cnt    = 4'(n_d);
							end
						end
					endcase
				end
			end
			SQ_WALK: begin
				if (k_q == '0) begin
					pick_d = '0;
					pf_d   = f_rd_q;
				end else if (f_rd_q < tgt_q) begin
					if (f_rd_q > pf_q) begin
						pick_d = k_q;
						pf_d   = f_rd_q;
					end
				end else if (f_rd_q < pf_q) begin
					pick_d = k_q;
					pf_d   = f_rd_q;
				end
				if (CNT_W'(k_q) == n - CNT_W'(1)) begin
					c_re    = 1'b1;
					c_ra    = pick_d;
					state_d = SQ_CTL;
				end else begin
					f_re = 1'b1;
					f_ra = k_q + IDX_W'(1);
					k_d  = k_q + IDX_W'(1);
				end
			end
			SQ_CTL: begin
				hw_c    = c_rd_q;
				hw_d    = hw_c;
				st_d    = (hw_c > max_ps_q) ? ST_LIMIT : ST_OK;
				cur_we  = (hw_c <= max_ps_q) && cpu_ok_q;
				cur_wd  = hw_c;
				f_re    = 1'b1;
				f_ra    = IDX_W'(hw_c);
				state_d = SQ_FO;
			end
			SQ_HW: begin
				hw_c    = cur_ok_q ? cur_rd_q : 3'd0;
				hw_d    = hw_c;
				st_d    = ST_OK;
				f_re    = 1'b1;
				f_ra    = IDX_W'(hw_c);
				state_d = SQ_FO;
			end
			SQ_FO: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec_byte && fwe) f_mem[ent_idx_q[IDX_W-1:0]] <= wfreq;
		if (exec_byte && cwe) c_mem[ent_idx_q[IDX_W-1:0]] <= acc_q[2:0];
		if (f_re) f_rd_q <= f_mem[f_ra];
		if (c_re) c_rd_q <= c_mem[c_ra];
		if (cur_we) cur_mem[cur_wa] <= cur_wd;
		if (cur_re) cur_rd_q <= cur_mem[cur_ra];
	end

	always_ff @(posedge clk) begin
		k_q    <= k_d;
		pick_q <= pick_d;
		pf_q   <= pf_d;
		tgt_q  <= tgt_d;
		cpu_q  <= cpu_d;
		hw_q   <= hw_d;
		st_q   <= st_d;
		acc_q  <= exec_byte ? acc_d : acc_q;
		if (load) begin
			o_status_q <= nx_status;
			o_done_q   <= nx_done;
			o_hw_q     <= nx_hw;
			o_fo_q     <= nx_fo;
			o_lo_q     <= nx_lo;
			o_hi_q     <= nx_hi;
			o_cnt_q    <= nx_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			byte_pos_q <= 3'd0;
			ent_exp_q  <= 8'd0;
			ent_idx_q  <= 8'd0;
			word_idx_q <= 3'd0;
			acc_hi_q   <= 1'b0;
			min_q      <= 16'hffff;
			max_q      <= 16'd0;
			max_ps_q   <= MAX_PS_RESET;
			state_q    <= SQ_IDLE;
			cpu_ok_q   <= 1'b0;
			cur_ok_q   <= 1'b0;
			cur_vld_q  <= '0;
			o_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) max_ps_q <= cfg_wdata;
			if (exec_byte) begin
				phase_q    <= phase_d;
				byte_pos_q <= byte_pos_d;
				ent_exp_q  <= ent_exp_d;
				ent_idx_q  <= ent_idx_d;
				word_idx_q <= word_idx_d;
				acc_hi_q   <= acc_hi_d;
				min_q      <= min_d;
				max_q      <= max_d;
			end
			state_q  <= state_d;
			cpu_ok_q <= cpu_ok_d;
			if (cur_re) cur_ok_q <= head_cpu_ok && cur_vld_q[cur_ra];
			if (cur_we) cur_vld_q[cur_wa] <= 1'b1;
			if (load) begin
				o_valid_q <= 1'b1;
			end else if (!out_stall) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = o_valid_q;
	assign status       = o_status_q;
	assign load_done    = o_done_q;
	assign hw_pstate    = o_hw_q;
	assign freq_out     = o_fo_q;
	assign lowest_freq  = o_lo_q;
	assign highest_freq = o_hi_q;
	assign state_count  = o_cnt_q;

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == SQ_IDLE))
		else $error("queue popped while sequencer busy");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_WALK) |-> (CNT_W'(k_q) < n))
		else $error("walk index beyond stored entries");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cur_we |-> (cur_wd <= max_ps_q))
		else $error("p-state recorded above limit");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_FO && !out_free) |=> (state_q == SQ_FO))
		else $error("pending result dropped while output busy");
`endif

endmodule
